FILE: hdl/epsilon_nfa_string_acceptor_unit_macros.svh
// Assertion macros for the epsilon-NFA string acceptor.
// Included by the top level only; no other dependencies.
`ifndef EPSILON_NFA_STRING_ACCEPTOR_UNIT_MACROS_SVH
`define EPSILON_NFA_STRING_ACCEPTOR_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define ENFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("enfa: same-cycle check failed");

// next-cycle implication, held off during reset
`define ENFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("enfa: next-cycle check failed");

`endif

FILE: hdl/enfa_pkg.sv
// Shared constants, codes and interface structs for the epsilon-NFA acceptor.
// No dependencies.
`default_nettype none

package enfa_pkg;

	localparam int NUM_STATES_DEF  = 16;
	localparam int NUM_SYMBOLS_DEF = 16;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int ST_FW     = 4;
	localparam int SYM_FW    = 4;
	localparam int ACC_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
	localparam logic [OP_W-1:0] OP_STRING = 2'd2;
	localparam logic [OP_W-1:0] OP_EMPTY  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT = 1'b1;

	// epsilon move
	localparam logic [SYM_FW-1:0] SYM_EPS = 4'd0;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_req;
	} tbl_ctl_t;

	typedef struct packed {
		logic clr_busy;
	} tbl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/enfa_tbl.sv
// Transition table: one destination mask per (state, symbol), single-port RAM
// with registered read and a clearing sweep after reset and on request. Uses enfa_pkg.
`default_nettype none

module enfa_tbl import enfa_pkg::*; #(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	localparam int DEPTH  = NUM_STATES * NUM_SYMBOLS,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tbl_ctl_t              ctl,
	input  wire logic [ADDR_W-1:0]     addr,
	input  wire logic [NUM_STATES-1:0] wdata,
	output logic      [NUM_STATES-1:0] rdata,
	output tbl_sts_t                   sts
);

	logic [NUM_STATES-1:0] rows_mem [DEPTH];
	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_cnt_q;

	// sweep one row a cycle; a new request restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (ctl.clr_req) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			rows_mem[clr_cnt_q] <= '0;
		end else if (ctl.wr_en) begin
			rows_mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata <= rows_mem[addr];
		end
	end

	assign sts.clr_busy = clr_busy_q;

endmodule

`default_nettype wire

FILE: hdl/epsilon_nfa_string_acceptor_unit.sv
// Epsilon-NFA string acceptor, top level; uses enfa_pkg, enfa_tbl and the macro header.
// The automaton's transitions live in a RAM of NUM_STATES*NUM_SYMBOLS destination masks,
// one per (state, symbol), symbol 0 being the epsilon move; the active state set is a
// register. Items are taken one at a time: in_stall is low only while the sequencer is
// idle and the table is not being cleared. After reset, and after every clear-table item,
// a sweep writes zero to every row, one row a cycle; configuration writes are still taken
// then. An insert is a read-modify-write of one row. A string symbol scans all states
// once to read the rows of the active ones, then closes the set over epsilon moves by
// walking a pointer round the states and reading the epsilon row of each newly active
// state once; the walk is shortest for an empty set and longest for a chain of epsilon
// moves that runs against the pointer. A first symbol, and the empty-string item, also
// close the start state first. An item that gives a result then loads it into the result
// register, waiting while a held result is stalled. The single RAM port sets the pace.
// A result sits in an output register, so the next item is taken while it waits.
`default_nettype none
`include "epsilon_nfa_string_acceptor_unit_macros.svh"

module epsilon_nfa_string_acceptor_unit import enfa_pkg::*; #(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [ST_FW-1:0]     from_state,
	input  wire logic [SYM_FW-1:0]    symbol,
	input  wire logic [ST_FW-1:0]     to_state,
	input  wire logic                 first,
	input  wire logic                 last,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      accepted,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0]    cfg_data
);

	localparam int DEPTH  = NUM_STATES * NUM_SYMBOLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ST_W   = $clog2(NUM_STATES);
	localparam int HIT_N  = (NUM_STATES < ACC_W) ? NUM_STATES : ACC_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;   // waiting for an item
	localparam logic [2:0] ST_INS  = 3'd1;   // write back the merged row
	localparam logic [2:0] ST_MOVE = 3'd2;   // scan rows of active states for the symbol
	localparam logic [2:0] ST_MDRN = 3'd3;   // pick up the last row read
	localparam logic [2:0] ST_CLOS = 3'd4;   // epsilon closure walk
	localparam logic [2:0] ST_FIN  = 3'd5;   // load the result register

	logic [2:0]            state_q;
	logic [NUM_STATES-1:0] set_q;      // active state set
	logic [NUM_STATES-1:0] done_q;     // states whose epsilon row has been read
	logic [NUM_STATES-1:0] acc_q;      // move result being gathered
	logic [ST_W-1:0]       ptr_q;
	logic                  rd_s1;      // a scan or closure row read was issued last cycle
	logic [SYM_FW-1:0]     sym_q;
	logic                  sym_ok_q;
	logic                  then_move_q;
	logic                  want_res_q;
	logic [ADDR_W-1:0]     ins_addr_q;
	logic [ST_FW-1:0]      to_q;
	logic [ST_FW-1:0]      start_q;
	logic [ACC_W-1:0]      accept_q;
	logic                  out_valid_q;
	logic                  accepted_q;

	tbl_ctl_t              ctl;
	tbl_sts_t              sts;
	logic [ADDR_W-1:0]     tbl_addr;
	logic [NUM_STATES-1:0] tbl_wdata;
	logic [NUM_STATES-1:0] tbl_rdata;

	logic                  in_acc;
	logic                  ins_ok;
	logic [NUM_STATES-1:0] start_set;
	logic [NUM_STATES-1:0] set_now;
	logic [NUM_STATES-1:0] pending;
	logic                  ptr_last;
	logic [ST_W-1:0]       ptr_nxt;
	logic [ACC_W-1:0]      set_acc;
	logic                  hit;
	logic                  res_load;

	function automatic logic [ADDR_W-1:0] row_addr(input logic [ADDR_W-1:0] st,
			input logic [ADDR_W-1:0] sy);
		return st * ADDR_W'(NUM_SYMBOLS) + sy;
	endfunction

	assign in_stall  = (state_q != ST_IDLE) || sts.clr_busy;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// out-of-range inserts are dropped
	assign ins_ok = (32'(from_state) < NUM_STATES) && (32'(symbol) < NUM_SYMBOLS)
		&& (32'(to_state) < NUM_STATES);

	assign start_set = (32'(start_q) < NUM_STATES) ? (NUM_STATES'(1) << start_q) : '0;

	// row data lands in the cycle after its read; fold it in before looking for work
	assign set_now  = set_q | (rd_s1 ? tbl_rdata : '0);
	assign pending  = set_now & ~done_q;
	assign ptr_last = (ptr_q == ST_W'(NUM_STATES - 1));
	assign ptr_nxt  = ptr_last ? '0 : ptr_q + 1'b1;

	// only the low sixteen states can be accepting
	always_comb begin
		set_acc = '0;
		for (int i = 0; i < HIT_N; i++) begin
			set_acc[i] = set_q[i];
		end
	end
	assign hit = |(set_acc & accept_q);

	// table port
	always_comb begin
		ctl       = '0;
		tbl_addr  = row_addr(ADDR_W'(ptr_q), ADDR_W'(sym_q));
		tbl_wdata = tbl_rdata | (NUM_STATES'(1) << to_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_INSERT && ins_ok) begin
					ctl.rd_en = 1'b1;
					tbl_addr  = row_addr(ADDR_W'(from_state), ADDR_W'(symbol));
				end
				if (in_acc && op == OP_CLEAR) begin
					ctl.clr_req = 1'b1;
				end
			end
			ST_INS: begin
				ctl.wr_en = 1'b1;
				tbl_addr  = ins_addr_q;
			end
			ST_MOVE: begin
				ctl.rd_en = set_q[ptr_q] && sym_ok_q;
			end
			ST_CLOS: begin
				ctl.rd_en = pending[ptr_q];
				tbl_addr  = row_addr(ADDR_W'(ptr_q), ADDR_W'(SYM_EPS));
			end
			default: begin
			end
		endcase
	end

	enfa_tbl #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addr   (tbl_addr),
		.wdata  (tbl_wdata),
		.rdata  (tbl_rdata),
		.sts    (sts)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_data[ST_FW-1:0];
				REG_ACCEPT: accept_q <= cfg_data[ACC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_q       <= '0;
			done_q      <= '0;
			acc_q       <= '0;
			ptr_q       <= '0;
			rd_s1       <= 1'b0;
			sym_q       <= '0;
			sym_ok_q    <= 1'b0;
			then_move_q <= 1'b0;
			want_res_q  <= 1'b0;
			ins_addr_q  <= '0;
			to_q        <= '0;
		end else begin
			rd_s1 <= ctl.rd_en && (state_q != ST_IDLE);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							OP_INSERT: begin
								if (ins_ok) begin
									ins_addr_q <= row_addr(ADDR_W'(from_state),
										ADDR_W'(symbol));
									to_q       <= to_state;
									state_q    <= ST_INS;
								end
							end
							OP_STRING: begin
								sym_q      <= symbol;
								sym_ok_q   <= (32'(symbol) < NUM_SYMBOLS);
								want_res_q <= last;
								ptr_q      <= '0;
								if (first) begin
									set_q       <= start_set;
									done_q      <= '0;
									then_move_q <= 1'b1;
									state_q     <= ST_CLOS;
								end else begin
									acc_q   <= '0;
									state_q <= ST_MOVE;
								end
							end
							OP_EMPTY: begin
								set_q       <= start_set;
								done_q      <= '0;
								ptr_q       <= '0;
								then_move_q <= 1'b0;
								want_res_q  <= 1'b1;
								state_q     <= ST_CLOS;
							end
							default: begin
								// clear: the table sweeps on its own, active set kept
							end
						endcase
					end
				end
				ST_INS: begin
					state_q <= ST_IDLE;
				end
				ST_MOVE: begin
					if (rd_s1) begin
						acc_q <= acc_q | tbl_rdata;
					end
					ptr_q <= ptr_nxt;
					if (ptr_last) begin
						state_q <= ST_MDRN;
					end
				end
				ST_MDRN: begin
					set_q   <= acc_q | (rd_s1 ? tbl_rdata : '0);
					done_q  <= '0;
					ptr_q   <= '0;
					state_q <= ST_CLOS;
				end
				ST_CLOS: begin
					set_q <= set_now;
					if (pending[ptr_q]) begin
						done_q[ptr_q] <= 1'b1;
					end
					// fixed point: nothing left unread and no row in flight
					if (pending == '0) begin
						if (then_move_q) begin
							then_move_q <= 1'b0;
							acc_q       <= '0;
							ptr_q       <= '0;
							state_q     <= ST_MOVE;
						end else if (want_res_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						ptr_q <= ptr_nxt;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	assign res_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			accepted_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

	// checks
	`ENFA_ASSERT_IMP(a_done_in_set, clk, arst_n, (state_q == ST_CLOS), ((done_q & ~set_q) == '0))
	`ENFA_ASSERT_IMP(a_no_rmw_in_sweep, clk, arst_n, sts.clr_busy, !ctl.wr_en)
	`ENFA_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(out_valid_q), ($past(state_q) == ST_FIN))
	`ENFA_ASSERT_NXT(a_clos_to_fin, clk, arst_n, (state_q == ST_CLOS && pending == '0 && !then_move_q && want_res_q), (state_q == ST_FIN))

endmodule

`default_nettype wire

FILE: bench/tb_epsilon_nfa_string_acceptor_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for epsilon_nfa_string_acceptor_unit: a directed table, then random automata.
// Depends on enfa_pkg and the unit's RTL; the state-set predictor and scoreboard live here.

module tb_epsilon_nfa_string_acceptor_unit;
	import enfa_pkg::*;

	localparam int NS     = NUM_STATES_DEF;
	localparam int NY     = NUM_SYMBOLS_DEF;
	localparam int LIMIT  = 4_000_000;  // cycles; slowest legal run taken several times over
	localparam int SETTLE = 1000;       // > a clear sweep or a worst-case first symbol
	localparam int HOLD   = 1500;       // long receiver hold-off
	localparam int ITEMS  = 1600;
	localparam int NSEG   = 6;          // random segments, two per idling mode

	typedef logic [NS-1:0] sset_t;

	// one row of the directed table: either a register setting or an item
	typedef struct packed {
		logic                  reconf;
		logic [ST_FW-1:0]      st;
		logic [ACC_W-1:0]      acc;
		logic [OP_W-1:0]       op;
		logic [ST_FW-1:0]      frm;
		logic [SYM_FW-1:0]     sym;
		logic [ST_FW-1:0]      dst;
		logic                  fst;
		logic                  lst;
		logic                  pin;      // expected verdict typed in
		logic                  pin_val;
	} drow_t;

	// block ports; everything driven to a known value from time zero
	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op         = '0;
	logic [ST_FW-1:0]     from_state = '0;
	logic [SYM_FW-1:0]    symbol     = '0;
	logic [ST_FW-1:0]     to_state   = '0;
	logic                 first      = 1'b0;
	logic                 last       = 1'b0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic                 accepted;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DW-1:0]    cfg_data   = '0;

	// travels alongside the item so the scoreboard sees it on the same edge
	logic pin_en  = 1'b0;
	logic pin_val = 1'b0;

	// predictor state: transition table, active set, registers
	sset_t            trans_tbl [NS][NY];
	sset_t            live_set;
	logic [ST_FW-1:0] cur_start;
	logic [ACC_W-1:0] cur_accept;
	bit               verdict_q [$];   // expected accepted bits, oldest first

	// directed table
	drow_t rows [$];

	int n_items = 0, n_results = 0, n_yes = 0, n_bad = 0, n_cfg = 0, cycles = 0;
	int hold_cnt = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;

	epsilon_nfa_string_acceptor_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.from_state (from_state),
		.symbol     (symbol),
		.to_state   (to_state),
		.first      (first),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_epsilon_nfa_string_acceptor_unit: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------ random fields

	function automatic logic [OP_W-1:0] rnd_op();
		return OP_W'($urandom);
	endfunction

	function automatic logic [ST_FW-1:0] rnd_st();
		return ST_FW'($urandom);
	endfunction

	function automatic logic [SYM_FW-1:0] rnd_sym();
		return SYM_FW'($urandom);
	endfunction

	function automatic logic rnd_bit();
		return 1'($urandom);
	endfunction

	// ---------------------------------------------------------------- predictor

	function automatic void clear_table();
		for (int s = 0; s < NS; s++)
			for (int y = 0; y < NY; y++)
				trans_tbl[s][y] = '0;
	endfunction

	// union of the rows of every active state for one symbol
	function automatic sset_t step_set(sset_t cur, int sym);
		sset_t nxt;
		nxt = '0;
		for (int s = 0; s < NS; s++)
			if (cur[s] && sym < NY)
				nxt |= trans_tbl[s][sym];
		return nxt;
	endfunction

	// grow over epsilon moves until nothing changes; NS passes always suffice
	function automatic sset_t eps_close(sset_t cur);
		sset_t grown;
		for (int i = 0; i < NS; i++) begin
			grown = cur | step_set(cur, int'(SYM_EPS));
			if (grown == cur)
				break;
			cur = grown;
		end
		return cur;
	endfunction

	function automatic sset_t start_set();
		if (int'(cur_start) >= NS)
			return '0;
		return eps_close(sset_t'(1) << cur_start);
	endfunction

	// applies one item; returns 1 when it yields a result, the verdict in acc
	function automatic bit predict_item(input logic [OP_W-1:0] o, input logic [ST_FW-1:0] f,
			input logic [SYM_FW-1:0] y, input logic [ST_FW-1:0] t, input logic fs,
			input logic ls, output bit acc);
		acc = 1'b0;
		case (o)
			OP_INSERT: begin
				if (f < NS && y < NY && t < NS)
					trans_tbl[f][y][t] = 1'b1;
				return 1'b0;
			end
			OP_CLEAR: begin
				clear_table();   // active set survives a clear
				return 1'b0;
			end
			OP_STRING: begin
				if (fs)
					live_set = start_set();
				live_set = eps_close(step_set(live_set, int'(y)));
				acc = |(ACC_W'(live_set) & cur_accept);
				return ls;
			end
			OP_EMPTY: begin
				live_set = start_set();
				acc = |(ACC_W'(live_set) & cur_accept);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_verdict(input bit v);
		verdict_q = {verdict_q, v};
	endfunction

	// --------------------------------------------------------------- scoreboard
	// Results are checked before the item of the same edge is predicted; a result
	// can never belong to an item taken on the same edge.
	always @(posedge clk) begin : scoreboard
		bit want, acc;
		if (!arst_n) begin
			clear_table();
			live_set   = '0;
			cur_start  = '0;
			cur_accept = '0;
			verdict_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (accepted)
					n_yes++;
				if (verdict_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result accepted=%b with none expected", $time, accepted);
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: accepted expected %b, got %b", $time, want, accepted);
					end
				end
			end
			if (in_valid && !in_stall)
				if (predict_item(op, from_state, symbol, to_state, first, last, acc))
					add_verdict(pin_en ? pin_val : acc);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START:  cur_start  = cfg_data[ST_FW-1:0];
					REG_ACCEPT: cur_accept = cfg_data[ACC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ----------------------------------------------------------------- receiver
	// Random stall per cycle, or a long hold-off counted down here when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cnt != 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
			end else
				out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------- sender

	// optional gap, then offer the item until taken; valid stays up afterwards
	task automatic send_item(input logic [OP_W-1:0] o, input logic [ST_FW-1:0] f,
			input logic [SYM_FW-1:0] y, input logic [ST_FW-1:0] t, input logic fs,
			input logic ls, input logic pe, input logic pv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op         <= o;
		from_state <= f;
		symbol     <= y;
		to_state   <= t;
		first      <= fs;
		last       <= ls;
		pin_en     <= pe;
		pin_val    <= pv;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_items++;
	endtask

	// sender pauses until every expected verdict has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// idle block, then both registers; start index carries junk in its upper bits
	task automatic set_regs(input logic [ST_FW-1:0] st, input logic [ACC_W-1:0] acc);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_index <= REG_START;
		cfg_data  <= {12'($urandom), st};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ACCEPT;
		cfg_data  <= acc;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// One random automaton: usually a fresh table, then a batch of test strings.
	// Most strings are well formed; a few are broken or plain noise.
	task automatic run_automaton();
		int n_st, k, len;
		logic [SYM_FW-1:0] y;
		if ($urandom_range(99) < 85)
			send_item(OP_CLEAR, rnd_st(), rnd_sym(), rnd_st(), rnd_bit(), rnd_bit(), 0, 0);
		n_st = ($urandom_range(3) == 0) ? NS : $urandom_range(8, 2);
		k    = $urandom_range(4, 1);
		if ($urandom_range(99) < 15) begin
			// epsilon chain running downwards, entered at the top state: slow closure
			for (int s = NS - 1; s > 0; s--)
				send_item(OP_INSERT, ST_FW'(s), SYM_EPS, ST_FW'(s - 1), 0, 0, 0, 0);
			for (int r = 0; r < 4; r++)
				send_item(OP_INSERT, ST_FW'(r), 1, ST_FW'(NS - 1), 0, 0, 0, 0);
		end else begin
			repeat ($urandom_range(3 * n_st, 3)) begin
				if ($urandom_range(3) == 0)
					y = SYM_EPS;
				else if ($urandom_range(19) == 0)
					y = rnd_sym();
				else
					y = SYM_FW'($urandom_range(k, 1));
				send_item(OP_INSERT, ST_FW'($urandom_range(n_st - 1)), y,
					ST_FW'($urandom_range(n_st - 1)), rnd_bit(), rnd_bit(), 0, 0);
			end
		end
		repeat ($urandom_range(10, 3)) begin
			len = $urandom_range(6, 1);
			case ($urandom_range(19))
				0, 1, 2: send_item(OP_EMPTY, rnd_st(), rnd_sym(), rnd_st(), rnd_bit(),
					rnd_bit(), 0, 0);
				3: send_item(rnd_op(), rnd_st(), rnd_sym(), rnd_st(), rnd_bit(), rnd_bit(), 0, 0);
				4: begin
					// broken: first and last fall anywhere
					for (int i = 0; i < len; i++)
						send_item(OP_STRING, rnd_st(), SYM_FW'($urandom_range(k)),
							rnd_st(), rnd_bit(), rnd_bit(), 0, 0);
				end
				default: begin
					for (int i = 0; i < len; i++) begin
						y = ($urandom_range(9) == 0) ? rnd_sym() : SYM_FW'($urandom_range(k, 1));
						send_item(OP_STRING, rnd_st(), y, rnd_st(), i == 0, i == len - 1, 0, 0);
					end
				end
			endcase
		end
	endtask

	function automatic drow_t d_item(input logic [OP_W-1:0] o, input logic [ST_FW-1:0] f,
			input logic [SYM_FW-1:0] y, input logic [ST_FW-1:0] t, input logic fs,
			input logic ls, input logic pe, input logic pv);
		drow_t r;
		r         = '0;
		r.op      = o;
		r.frm     = f;
		r.sym     = y;
		r.dst     = t;
		r.fst     = fs;
		r.lst     = ls;
		r.pin     = pe;
		r.pin_val = pv;
		return r;
	endfunction

	function automatic drow_t d_regs(input logic [ST_FW-1:0] st, input logic [ACC_W-1:0] acc);
		drow_t r;
		r        = '0;
		r.reconf = 1'b1;
		r.st     = st;
		r.acc    = acc;
		return r;
	endfunction

	function automatic void add_row(input drow_t r);
		rows = {rows, r};
	endfunction

	// ---------------------------------------------------------------- main flow
	initial begin : stimulus
		int    seg_end;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		// straight after reset: no accepting states, and an empty active set
		add_row(d_item(OP_EMPTY, 0, 0, 0, 0, 0, 1, 0));
		add_row(d_item(OP_STRING, 0, 5, 0, 0, 1, 1, 0));
		add_row(d_regs(0, 16'h8000));
		// empty table, all-ones fields on an item that ignores them
		add_row(d_item(OP_EMPTY, 15, 15, 15, 1, 1, 1, 0));
		// epsilon cycle 0 <-> 1, then a duplicate insert
		add_row(d_item(OP_INSERT, 0, SYM_EPS, 1, 0, 0, 0, 0));
		add_row(d_item(OP_INSERT, 1, SYM_EPS, 0, 0, 0, 0, 0));
		add_row(d_item(OP_INSERT, 1, 15, 15, 1, 1, 0, 0));
		add_row(d_item(OP_INSERT, 1, 15, 15, 0, 0, 0, 0));
		add_row(d_item(OP_INSERT, 15, SYM_EPS, 2, 0, 0, 0, 0));
		add_row(d_item(OP_STRING, 0, 15, 0, 1, 1, 0, 0));
		// epsilon fed as a string symbol, then continued without first
		add_row(d_item(OP_STRING, 0, SYM_EPS, 0, 1, 0, 0, 0));
		add_row(d_item(OP_STRING, 0, 15, 0, 0, 1, 0, 0));
		// symbol with no row empties the set; continuing keeps it empty
		add_row(d_item(OP_STRING, 0, 7, 0, 1, 1, 0, 0));
		add_row(d_item(OP_STRING, 15, 15, 15, 0, 1, 0, 0));
		// active set survives a table clear
		add_row(d_item(OP_STRING, 0, 15, 0, 1, 0, 0, 0));
		add_row(d_item(OP_CLEAR, 15, 15, 15, 1, 1, 0, 0));
		add_row(d_item(OP_INSERT, 2, 3, 15, 0, 0, 0, 0));
		add_row(d_item(OP_STRING, 0, 3, 0, 0, 1, 0, 0));
		// top start state, every state accepting
		add_row(d_regs(ST_FW'(NS - 1), 16'hFFFF));
		add_row(d_item(OP_EMPTY, 0, 0, 0, 0, 0, 1, 1));
		add_row(d_item(OP_INSERT, 15, 15, 15, 1, 1, 0, 0));
		add_row(d_item(OP_STRING, 0, 15, 0, 1, 1, 0, 0));
		add_row(d_item(OP_INSERT, 0, 0, 0, 0, 0, 0, 0));
		add_row(d_regs(0, 16'h0000));
		add_row(d_item(OP_EMPTY, 0, 0, 0, 0, 0, 1, 0));

		send_idle_pct = 30;
		recv_idle_pct = 73;
		foreach (rows[i]) begin
			if (rows[i].reconf)
				set_regs(rows[i].st, rows[i].acc);
			else
				send_item(rows[i].op, rows[i].frm, rows[i].sym, rows[i].dst, rows[i].fst,
					rows[i].lst, rows[i].pin, rows[i].pin_val);
		end

		// random part: sender-light/receiver-heavy, swapped, then no idling at all
		for (int seg = 0; seg < NSEG; seg++) begin
			send_idle_pct = (seg < 2) ? 30 : (seg < 4) ? 73 : 0;
			recv_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 30 : 0;
			case (seg)
				1:       set_regs(ST_FW'(NS - 1), 16'hFFFF);
				2:       set_regs(0, 16'h0001);
				4:       set_regs(0, 16'h8000);
				default: set_regs(ST_FW'($urandom_range(3)), ACC_W'($urandom));
			endcase
			// receiver sits on one result while items keep coming: block backs up
			if (seg == 4)
				hold_cnt = HOLD;
			seg_end = n_items + (ITEMS - rows.size()) / NSEG;
			while (n_items < seg_end)
				run_automaton();
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		$display("%0d items, %0d results (%0d accepting), %0d register settings, %0d cycles",
			n_items, n_results, n_yes, n_cfg, cycles);
		$display("mismatches: %0d", n_bad);
		if (n_bad == 0 && verdict_q.size() == 0)
			$display("tb_epsilon_nfa_string_acceptor_unit: clean");
		else
			$display("tb_epsilon_nfa_string_acceptor_unit: errors");
		$finish;
	end

endmodule
